@@ rtl/core/tkns_pkg.sv @@
package tkns_pkg;

    // configuration port
    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 20;

    localparam logic [CFG_ADDR_BITS-1:0] CFG_KEEP_COUNT  = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_SKIP_ENABLE = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_QUERY_INDEX = 2'd2;

    localparam int KEEP_COUNT_BITS  = 5;
    localparam int QUERY_INDEX_BITS = 20;

    // control broadcast to every cell
    typedef struct packed {
        logic insert;  // place the candidate this cycle
        logic grow;    // list may take one more entry
        logic shift;   // move entries one cell toward the head
    } cell_ctrl_t;

endpackage

@@ rtl/core/top_k_nearest_selector.sv @@
// timing: a candidate is placed in the edge that accepts it; after the final
//   candidate the block drains and the kept entries follow on out_valid, best first
// throughput: one candidate per cycle while not busy; a final candidate starts
//   the head-shift drain, which holds busy until all kept entries have left
// reset: rst_n sets the list count, state and config registers to their defaults
// the receiver cannot stall: each result shows for exactly one cycle
module top_k_nearest_selector
    import tkns_pkg::*;
#(
    parameter int K_MAX      = 16,
    parameter int INDEX_BITS = 20,
    parameter int DIST_BITS  = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [INDEX_BITS-1:0]    cand_index,
    input  logic [DIST_BITS-1:0]     cand_distance,
    input  logic                     final_cand,
    input  logic                     cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    output logic                     out_valid,
    output logic [INDEX_BITS-1:0]    out_index,
    output logic [DIST_BITS-1:0]     out_distance,
    output logic                     out_last
);

    // count holds 0..K_MAX
    localparam int CNT_BITS = $clog2(K_MAX + 1);
    // common width for comparing the count with keep_count
    localparam int KB = (CNT_BITS > KEEP_COUNT_BITS) ? CNT_BITS : KEEP_COUNT_BITS;
    // common width for the query index compare
    localparam int QB = (INDEX_BITS > QUERY_INDEX_BITS) ? INDEX_BITS : QUERY_INDEX_BITS;

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic                        state_reg;
    logic                        state_next;
    logic [CNT_BITS-1:0]         count_reg;
    logic [CNT_BITS-1:0]         count_next;
    logic [KEEP_COUNT_BITS-1:0]  keep_count_reg;
    logic                        skip_enable_reg;
    logic [QUERY_INDEX_BITS-1:0] query_index_reg;

    logic                        accept;
    logic                        skip;
    logic                        grow;
    logic [KB-1:0]               k_eff;
    cell_ctrl_t                  ctrl;

    // chain links: slot i feeds cell i from the left, cell i drives slot i+1
    logic [INDEX_BITS-1:0]       link_idx [K_MAX+2];
    logic [DIST_BITS-1:0]        link_dst [K_MAX+2];
    logic                        link_sel [K_MAX+1];
    logic                        link_vld [K_MAX+1];

    // ---------------- configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_count_reg  <= KEEP_COUNT_BITS'(16);
            skip_enable_reg <= 1'b0;
            query_index_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_KEEP_COUNT:  keep_count_reg  <= cfg_data[KEEP_COUNT_BITS-1:0];
                CFG_SKIP_ENABLE: skip_enable_reg <= cfg_data[0];
                CFG_QUERY_INDEX: query_index_reg <= cfg_data[QUERY_INDEX_BITS-1:0];
                default:         ;
            endcase
        end
    end

    // ---------------- item acceptance and list control
    assign busy   = (state_reg == ST_DRAIN);
    assign accept = start && !busy;

    // the query entry itself is dropped but a final one still closes the set
    assign skip = skip_enable_reg &&
                  (QB'(cand_index) == QB'(query_index_reg));

    // keep_count above K_MAX saturates
    assign k_eff = (KB'(keep_count_reg) > KB'(K_MAX)) ? KB'(K_MAX) : KB'(keep_count_reg);
    assign grow  = KB'(count_reg) < k_eff;

    assign ctrl.insert = accept && !skip;
    assign ctrl.grow   = grow;
    assign ctrl.shift  = busy;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (ctrl.insert && grow)
                begin
                    count_next = count_reg + CNT_BITS'(1);
                end
                if (accept && final_cand)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // head leaves each cycle; an empty list ends the drain
                if (count_reg != '0)
                begin
                    count_next = count_reg - CNT_BITS'(1);
                end
                if (count_reg <= CNT_BITS'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // ---------------- cell chain, best entry in cell 0
    assign link_idx[0]       = cand_index;
    assign link_dst[0]       = cand_distance;
    assign link_sel[0]       = 1'b0;
    assign link_vld[0]       = 1'b1;
    assign link_idx[K_MAX+1] = '0;
    assign link_dst[K_MAX+1] = '0;

    for (genvar i = 0; i < K_MAX; i++)
    begin : g_cell
        // entries below the count are live
        assign link_vld[i+1] = count_reg > CNT_BITS'(i);

        tkns_cell #(
            .INDEX_BITS (INDEX_BITS),
            .DIST_BITS  (DIST_BITS)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .valid      (link_vld[i+1]),
            .cand_idx   (cand_index),
            .cand_dst   (cand_distance),
            .prev_valid (link_vld[i]),
            .prev_sel   (link_sel[i]),
            .prev_idx   (link_idx[i]),
            .prev_dst   (link_dst[i]),
            .nxt_idx    (link_idx[i+2]),
            .nxt_dst    (link_dst[i+2]),
            .sel        (link_sel[i+1]),
            .idx        (link_idx[i+1]),
            .dst        (link_dst[i+1])
        );
    end

    // ---------------- results straight from the head cell
    assign out_valid    = busy && (count_reg != '0);
    assign out_index    = link_idx[1];
    assign out_distance = link_dst[1];
    assign out_last     = (count_reg == CNT_BITS'(1));

endmodule

@@ rtl/core/tkns_cell.sv @@
module tkns_cell
    import tkns_pkg::*;
#(
    parameter int INDEX_BITS = 20,
    parameter int DIST_BITS  = 16
)
(
    input  logic                  clk,
    input  cell_ctrl_t            ctrl,
    input  logic                  valid,
    input  logic [INDEX_BITS-1:0] cand_idx,
    input  logic [DIST_BITS-1:0]  cand_dst,
    input  logic                  prev_valid,
    input  logic                  prev_sel,
    input  logic [INDEX_BITS-1:0] prev_idx,
    input  logic [DIST_BITS-1:0]  prev_dst,
    input  logic [INDEX_BITS-1:0] nxt_idx,
    input  logic [DIST_BITS-1:0]  nxt_dst,
    output logic                  sel,
    output logic [INDEX_BITS-1:0] idx,
    output logic [DIST_BITS-1:0]  dst
);

    logic [INDEX_BITS-1:0] idx_reg;
    logic [INDEX_BITS-1:0] idx_next;
    logic [DIST_BITS-1:0]  dst_reg;
    logic [DIST_BITS-1:0]  dst_next;
    logic                  better;

    // candidate strictly better than the held entry
    assign better = (cand_dst < dst_reg) || ((cand_dst == dst_reg) && (cand_idx < idx_reg));
    assign sel    = valid && better;
    assign idx    = idx_reg;
    assign dst    = dst_reg;

    always_comb
    begin
        idx_next = idx_reg;
        dst_next = dst_reg;
        if (ctrl.shift)
        begin
            idx_next = nxt_idx;
            dst_next = nxt_dst;
        end
        else if (ctrl.insert && (valid || (prev_valid && ctrl.grow)))
        begin
            if (prev_sel)
            begin
                idx_next = prev_idx;
                dst_next = prev_dst;
            end
            else if (better || !valid)
            begin
                idx_next = cand_idx;
                dst_next = cand_dst;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        dst_reg <= dst_next;
    end

endmodule

@@ rtl/core/tkns_checker.sv @@
module tkns_checker
    import tkns_pkg::*;
#(
    parameter int INDEX_BITS = 20,
    parameter int DIST_BITS  = 16
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  final_cand,
    input logic                  out_valid,
    input logic                  out_last,
    input logic [INDEX_BITS-1:0] out_index,
    input logic [DIST_BITS-1:0]  out_distance
);

    // results appear only while the block is draining
    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> busy)
        else $error("result outside drain");

    // a final item starts the drain
    a_final_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && final_cand) |=> busy)
        else $error("final item did not start drain");

    // results of one set come back to back
    a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_last) |=> out_valid)
        else $error("gap in result list");

    // the last result frees the block
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_last) |=> !busy)
        else $error("still busy after last result");

    // a shown result only carries written entries
    a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown({out_index, out_distance, out_last}))
        else $error("unknown bits on a result");

endmodule

bind top_k_nearest_selector tkns_checker #(
    .INDEX_BITS (INDEX_BITS),
    .DIST_BITS  (DIST_BITS)
) u_tkns_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .final_cand   (final_cand),
    .out_valid    (out_valid),
    .out_last     (out_last),
    .out_index    (out_index),
    .out_distance (out_distance)
);
